### sv/zoom_flip_window_address_gen_defines.svh
// Assertion macros for the zoom/flip/window address generator.
// Expects clk and rst_n in the scope of each use.
`ifndef ZOOM_FLIP_WINDOW_ADDRESS_GEN_DEFINES_SVH
`define ZOOM_FLIP_WINDOW_ADDRESS_GEN_DEFINES_SVH

// same-cycle implication
`define ZFW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define ZFW_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

### sv/zfw_pkg.sv
// Shared types and constants of the zoom/flip/window address generator.
// No dependencies.
`default_nettype none

package zfw_pkg;

  localparam int WIN_W    = 13;
  localparam int STRIDE_W = 14;
  localparam int FLIP_W   = 2;
  localparam int ZOOM_W   = 6;

  localparam int APB_DW = 32;
  localparam int APB_AW = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_WIN_X_START = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIN_X_END   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WIN_Y_START = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WIN_Y_END   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SRC_BASE    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SRC_STRIDE  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FLIP_MODE   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ZOOM_FACTOR = 3'd7;

  localparam int FLIP_X_BIT = 0;
  localparam int FLIP_Y_BIT = 1;
  localparam logic [FLIP_W-1:0] FLIP_NONE = 2'b00;

  typedef struct packed {
    logic [WIN_W-1:0]           win_x_start;
    logic [WIN_W-1:0]           win_x_end;
    logic [WIN_W-1:0]           win_y_start;
    logic [WIN_W-1:0]           win_y_end;
    logic [STRIDE_W-1:0]        src_stride;
    logic [FLIP_W-1:0]          flip_mode;
    logic signed [ZOOM_W-1:0]   zoom_factor;
  } zfw_cfg_t;

endpackage

`default_nettype wire

### sv/zfw_cfg_regs.sv
// APB configuration register file: window, base, stride, flip and zoom.
// Depends on zfw_pkg.
`default_nettype none

module zfw_cfg_regs
  import zfw_pkg::*;
#(
  parameter int ADDR_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_AW-1:0]     paddr,
  input  wire logic [APB_DW-1:0]     pwdata,
  output logic      [APB_DW-1:0]     prdata,
  output logic                       pready,
  output zfw_cfg_t                   cfg,
  output logic      [ADDR_BITS-1:0]  src_base
);

  zfw_cfg_t               cfg_r, cfg_nxt;
  logic [ADDR_BITS-1:0]   base_r, base_nxt;
  logic [REG_IDX_W-1:0]   idx;
  logic                   wr_en;

  assign idx   = paddr[APB_AW-1:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt  = cfg_r;
    base_nxt = base_r;
    if (wr_en) begin
      case (idx)
        REG_WIN_X_START: cfg_nxt.win_x_start = pwdata[WIN_W-1:0];
        REG_WIN_X_END:   cfg_nxt.win_x_end   = pwdata[WIN_W-1:0];
        REG_WIN_Y_START: cfg_nxt.win_y_start = pwdata[WIN_W-1:0];
        REG_WIN_Y_END:   cfg_nxt.win_y_end   = pwdata[WIN_W-1:0];
        REG_SRC_BASE:    base_nxt            = pwdata[ADDR_BITS-1:0];
        REG_SRC_STRIDE:  cfg_nxt.src_stride  = pwdata[STRIDE_W-1:0];
        REG_FLIP_MODE:   cfg_nxt.flip_mode   = pwdata[FLIP_W-1:0];
        REG_ZOOM_FACTOR: cfg_nxt.zoom_factor = $signed(pwdata[ZOOM_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.win_x_start <= '0;
      cfg_r.win_x_end   <= '0;
      cfg_r.win_y_start <= '0;
      cfg_r.win_y_end   <= '0;
      cfg_r.src_stride  <= STRIDE_W'(1);
      cfg_r.flip_mode   <= FLIP_NONE;
      cfg_r.zoom_factor <= ZOOM_W'(1);
      base_r            <= '0;
    end else begin
      cfg_r  <= cfg_nxt;
      base_r <= base_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_WIN_X_START: prdata = APB_DW'(cfg_r.win_x_start);
      REG_WIN_X_END:   prdata = APB_DW'(cfg_r.win_x_end);
      REG_WIN_Y_START: prdata = APB_DW'(cfg_r.win_y_start);
      REG_WIN_Y_END:   prdata = APB_DW'(cfg_r.win_y_end);
      REG_SRC_BASE:    prdata = APB_DW'(base_r);
      REG_SRC_STRIDE:  prdata = APB_DW'(cfg_r.src_stride);
      REG_FLIP_MODE:   prdata = APB_DW'(cfg_r.flip_mode);
      REG_ZOOM_FACTOR: prdata = APB_DW'($unsigned(cfg_r.zoom_factor));
      default:         prdata = '0;
    endcase
  end

  assign cfg      = cfg_r;
  assign src_base = base_r;

endmodule

`default_nettype wire

### sv/zfw_window.sv
// Front stage: window test, offsets from the window start, zoom decode
// and reciprocal lookup. Depends on zfw_pkg.
`default_nettype none

module zfw_window
  import zfw_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int MAX_ZOOM   = 16,
  localparam int ZL    = $clog2(MAX_ZOOM),
  localparam int SHIFT = COORD_BITS + ZL,
  localparam int RW    = SHIFT + 1,
  localparam int DW    = $clog2(MAX_ZOOM + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_req,
  input  wire logic [COORD_BITS-1:0]  x,
  input  wire logic [COORD_BITS-1:0]  y,
  input  wire zfw_cfg_t               cfg,
  output logic                        v_o,
  output logic                        bg_o,
  output logic      [COORD_BITS-1:0]  offx_o,
  output logic      [COORD_BITS-1:0]  offy_o,
  output logic      [RW-1:0]          recip_o,
  output logic      [DW-1:0]          dec_o
);

  localparam int XW = (COORD_BITS > WIN_W) ? COORD_BITS : WIN_W;

  // ceil(2^SHIFT / d): exact floor division for offsets below 2^COORD_BITS
  logic [2**DW-1:0][RW-1:0] recip_tab;
  for (genvar d = 0; d < 2**DW; d++) begin : g_recip
    localparam int DIV = (d == 0) ? 1 : d;
    localparam int VAL = ((1 << SHIFT) + DIV - 1) / DIV;
    assign recip_tab[d] = RW'(VAL);
  end

  logic [XW-1:0]        xe, ye;
  logic                 bg;
  logic signed [6:0]    zx;
  logic [6:0]           mag, clamp;
  logic                 big;
  logic [DW-1:0]        rep, dec;

  assign xe = XW'(x);
  assign ye = XW'(y);
  assign bg = (xe <  XW'(cfg.win_x_start)) || (xe >= XW'(cfg.win_x_end)) ||
              (ye <  XW'(cfg.win_y_start)) || (ye >= XW'(cfg.win_y_end));

  // zoom of -1, 0 and 1 all mean no scaling
  assign zx    = 7'(cfg.zoom_factor);
  assign mag   = zx[6] ? 7'(-zx) : 7'(zx);
  assign clamp = (mag > 7'(MAX_ZOOM)) ? 7'(MAX_ZOOM) : mag;
  assign big   = mag > 7'd1;
  assign rep   = (big && !zx[6]) ? DW'(clamp) : DW'(1);
  assign dec   = (big &&  zx[6]) ? DW'(clamp) : DW'(1);

  logic                   v_r;
  logic                   bg_r;
  logic [COORD_BITS-1:0]  offx_r, offy_r;
  logic [RW-1:0]          recip_r;
  logic [DW-1:0]          dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    bg_r    <= bg;
    offx_r  <= COORD_BITS'(xe - XW'(cfg.win_x_start));
    offy_r  <= COORD_BITS'(ye - XW'(cfg.win_y_start));
    recip_r <= recip_tab[rep];
    dec_r   <= dec;
  end

  assign v_o     = v_r;
  assign bg_o    = bg_r;
  assign offx_o  = offx_r;
  assign offy_o  = offy_r;
  assign recip_o = recip_r;
  assign dec_o   = dec_r;

endmodule

`default_nettype wire

### sv/zfw_scale.sv
// Multiply stages: reciprocal divide, decimation scale, row stride scale.
// Depends on zfw_pkg.
`default_nettype none

module zfw_scale
  import zfw_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int MAX_ZOOM   = 16,
  localparam int ZL    = $clog2(MAX_ZOOM),
  localparam int SHIFT = COORD_BITS + ZL,
  localparam int RW    = SHIFT + 1,
  localparam int DW    = $clog2(MAX_ZOOM + 1),
  localparam int TW    = COORD_BITS + DW,
  localparam int YW    = TW + STRIDE_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   v_i,
  input  wire logic                   bg_i,
  input  wire logic [COORD_BITS-1:0]  offx_i,
  input  wire logic [COORD_BITS-1:0]  offy_i,
  input  wire logic [RW-1:0]          recip_i,
  input  wire logic [DW-1:0]          dec_i,
  input  wire logic [STRIDE_W-1:0]    stride,
  output logic                        v_o,
  output logic                        bg_o,
  output logic      [TW-1:0]          tx_o,
  output logic      [YW-1:0]          tys_o
);

  localparam int PW = COORD_BITS + RW;

  logic [PW-1:0] px, py;
  assign px = PW'(offx_i) * PW'(recip_i);
  assign py = PW'(offy_i) * PW'(recip_i);

  // stage A: quotients
  logic                   va_r, bga_r;
  logic [COORD_BITS-1:0]  qx_r, qy_r;
  logic [DW-1:0]          deca_r;
  // stage B: decimation scaled steps
  logic                   vb_r, bgb_r;
  logic [TW-1:0]          txb_r, tyb_r;
  // stage C: row step scaled by stride
  logic                   vc_r, bgc_r;
  logic [TW-1:0]          txc_r;
  logic [YW-1:0]          tysc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= v_i;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    bga_r  <= bg_i;
    qx_r   <= px[SHIFT +: COORD_BITS];
    qy_r   <= py[SHIFT +: COORD_BITS];
    deca_r <= dec_i;

    bgb_r  <= bga_r;
    txb_r  <= TW'(qx_r) * TW'(deca_r);
    tyb_r  <= TW'(qy_r) * TW'(deca_r);

    bgc_r  <= bgb_r;
    txc_r  <= txb_r;
    tysc_r <= YW'(tyb_r) * YW'(stride);
  end

  assign v_o   = vc_r;
  assign bg_o  = bgc_r;
  assign tx_o  = txc_r;
  assign tys_o = tysc_r;

endmodule

`default_nettype wire

### sv/zfw_addr.sv
// Final stage: signed sum of base and flipped steps, saturation, result
// register with strobe. Depends on zfw_pkg.
`default_nettype none

module zfw_addr
  import zfw_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int ADDR_BITS  = 24,
  parameter int MAX_ZOOM   = 16,
  localparam int DW = $clog2(MAX_ZOOM + 1),
  localparam int TW = COORD_BITS + DW,
  localparam int YW = TW + STRIDE_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  v_i,
  input  wire logic                  bg_i,
  input  wire logic [TW-1:0]         tx_i,
  input  wire logic [YW-1:0]         tys_i,
  input  wire logic [FLIP_W-1:0]     flip,
  input  wire logic [ADDR_BITS-1:0]  base,
  output logic                       v_o,
  output logic                       bg_o,
  output logic      [ADDR_BITS-1:0]  addr_o
);

  localparam int SW = ((ADDR_BITS > YW) ? ADDR_BITS : YW) + 2;

  logic signed [SW-1:0] sb, stx, sty, sum, amax;
  logic [ADDR_BITS-1:0] addr;

  assign sb   = SW'(base);
  assign stx  = flip[FLIP_X_BIT] ? -SW'(tx_i)  : SW'(tx_i);
  assign sty  = flip[FLIP_Y_BIT] ? -SW'(tys_i) : SW'(tys_i);
  assign sum  = sb + stx + sty;
  assign amax = SW'({ADDR_BITS{1'b1}});

  always_comb begin
    if (bg_i || sum[SW-1]) begin
      addr = '0;
    end else if (sum > amax) begin
      addr = '1;
    end else begin
      addr = sum[ADDR_BITS-1:0];
    end
  end

  logic                  v_r, bg_r;
  logic [ADDR_BITS-1:0]  addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    bg_r   <= bg_i;
    addr_r <= addr;
  end

  assign v_o    = v_r;
  assign bg_o   = bg_r;
  assign addr_o = addr_r;

endmodule

`default_nettype wire

### sv/zoom_flip_window_address_gen.sv
// Zoom/flip/window source address generator, top level; uses zfw_pkg and all zfw_ modules.
// Throughput: one request per clock; busy is low in normal operation, so
// the five-stage pipeline (window, divide, decimate, stride, sum) never stalls.
// Reset: synchronous rst_n clears the stage valids and sets busy, which drops in the cycle after rst_n is released.
`default_nettype none
`include "zoom_flip_window_address_gen_defines.svh"

module zoom_flip_window_address_gen
  import zfw_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int ADDR_BITS  = 24,
  parameter int MAX_ZOOM   = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // request channel
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [COORD_BITS-1:0]  in_out_x,
  input  wire logic [COORD_BITS-1:0]  in_out_y,
  // result channel, one-cycle strobe
  output logic                        out_valid,
  output logic                        out_is_background,
  output logic      [ADDR_BITS-1:0]   out_source_address,
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_AW-1:0]      paddr,
  input  wire logic [APB_DW-1:0]      pwdata,
  output logic      [APB_DW-1:0]      prdata,
  output logic                        pready
);

  localparam int ZL    = $clog2(MAX_ZOOM);
  localparam int RW    = COORD_BITS + ZL + 1;
  localparam int DW    = $clog2(MAX_ZOOM + 1);
  localparam int TW    = COORD_BITS + DW;
  localparam int YW    = TW + STRIDE_W;
  localparam int LAT   = 5;

  zfw_cfg_t              cfg;
  logic [ADDR_BITS-1:0]  src_base;

  // busy only covers the cycles around reset; the pipeline takes a
  // request every clock otherwise.
  logic busy_r;
  logic req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign req  = start && !busy_r;

  zfw_cfg_regs #(
    .ADDR_BITS (ADDR_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .src_base (src_base)
  );

  // stage 1: window test, offsets, zoom decode
  logic                   w_v, w_bg;
  logic [COORD_BITS-1:0]  w_offx, w_offy;
  logic [RW-1:0]          w_recip;
  logic [DW-1:0]          w_dec;

  zfw_window #(
    .COORD_BITS (COORD_BITS),
    .MAX_ZOOM   (MAX_ZOOM)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req),
    .x       (in_out_x),
    .y       (in_out_y),
    .cfg     (cfg),
    .v_o     (w_v),
    .bg_o    (w_bg),
    .offx_o  (w_offx),
    .offy_o  (w_offy),
    .recip_o (w_recip),
    .dec_o   (w_dec)
  );

  // stages 2-4: divide by replicate factor, decimate, row stride
  logic             s_v, s_bg;
  logic [TW-1:0]    s_tx;
  logic [YW-1:0]    s_tys;

  zfw_scale #(
    .COORD_BITS (COORD_BITS),
    .MAX_ZOOM   (MAX_ZOOM)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .v_i     (w_v),
    .bg_i    (w_bg),
    .offx_i  (w_offx),
    .offy_i  (w_offy),
    .recip_i (w_recip),
    .dec_i   (w_dec),
    .stride  (cfg.src_stride),
    .v_o     (s_v),
    .bg_o    (s_bg),
    .tx_o    (s_tx),
    .tys_o   (s_tys)
  );

  // stage 5: base plus signed steps, clamp, result register
  zfw_addr #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS),
    .MAX_ZOOM   (MAX_ZOOM)
  ) u_addr (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_i    (s_v),
    .bg_i   (s_bg),
    .tx_i   (s_tx),
    .tys_i  (s_tys),
    .flip   (cfg.flip_mode),
    .base   (src_base),
    .v_o    (out_valid),
    .bg_o   (out_is_background),
    .addr_o (out_source_address)
  );

  // every request yields exactly one result
  `ZFW_ASSERT_DLY(a_req_to_result, start && !busy, LAT, out_valid,
    "request did not produce a result")
  `ZFW_ASSERT_IMP(a_result_has_req, out_valid, $past(start && !busy, LAT),
    "result without a matching request")
  // unflipped stepping only moves forward from the base
  `ZFW_ASSERT_IMP(a_noflip_above_base,
    out_valid && !out_is_background && (cfg.flip_mode == FLIP_NONE),
    out_source_address >= src_base, "unflipped address below base")

endmodule

`default_nettype wire
